// ===== rtl/jtgd_pkg.sv =====
// Shared types and constants of the Japanese text glyph decoder.
// No dependencies; every rtl file of the block imports this package.
package jtgd_pkg;

    // Decoding modes held in the mode register (other codes decode as plain bytes)
    localparam logic [1:0] LANG_SJIS = 2'd1;
    localparam logic [1:0] LANG_EUC  = 2'd2;

    // Lead byte ranges
    localparam logic [7:0] SJIS_LEAD_A_LO = 8'h81;
    localparam logic [7:0] SJIS_LEAD_A_HI = 8'h9f;
    localparam logic [7:0] SJIS_LEAD_B_LO = 8'he0;
    localparam logic [7:0] SJIS_LEAD_B_HI = 8'hfc;
    localparam logic [7:0] EUC_LEAD_LO    = 8'h81;
    localparam logic [7:0] EUC_LEAD_HI    = 8'hfe;

    // Shift-JIS trail byte ranges
    localparam logic [7:0] SJIS_TRAIL_A_LO = 8'h40;
    localparam logic [7:0] SJIS_TRAIL_A_HI = 8'h7e;
    localparam logic [7:0] SJIS_TRAIL_B_LO = 8'h80;
    localparam logic [7:0] SJIS_TRAIL_B_HI = 8'h9e;

    // Signed arithmetic on row and cell
    localparam int                 CELL_W       = 16;
    localparam logic signed [15:0] SJIS_BASE_A  = 16'sh0081;
    localparam logic signed [15:0] SJIS_BASE_B  = 16'sh00e0;
    localparam logic signed [15:0] SJIS_ROW_B   = 16'sd62;
    localparam logic signed [15:0] SJIS_TR_A    = 16'sh0040;
    localparam logic signed [15:0] SJIS_TR_B    = 16'sd65;   // 0x80 - 63
    localparam logic signed [15:0] SJIS_TR_C    = 16'sh009f;
    localparam logic signed [15:0] EUC_BASE     = 16'sh00a1;
    localparam logic signed [15:0] CELLS_PER_ROW = 16'sd94;

    // Pen column
    localparam logic [11:0] COL_MAX  = 12'hfff;
    localparam logic [11:0] COL_SAT  = 12'd4087;
    localparam logic [11:0] COL_STEP = 12'd8;

    localparam logic [18:0]        NAT_BASE   = 19'd4096;
    localparam logic [18:0]        HALF_OFS   = 19'd16;
    localparam logic signed [12:0] GLYPH_W    = 13'sd8;

    // Decoded command passed from front to back through the queue
    typedef struct packed {
        logic        is_double;
        logic        font_select;
        logic [18:0] glyph_offset;
        logic [11:0] column;
        logic        bad_code;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic               font_select;
        logic [18:0]        glyph_offset;
        logic signed [12:0] draw_x;
        logic               bad_code;
        logic               last;
    } t_result;

endpackage

// ===== rtl/japanese_text_glyph_decoder_unit.sv =====
// Top level of the Japanese text glyph decoder.
// Uses jtgd_pkg, jtgd_front, jtgd_queue and jtgd_back.

// Turns a stream of text bytes into glyph fetch commands for a text display.
// The mode register selects plain single-byte text (0, and the unused code 3),
// Shift-JIS (1) or EUC-JP (2). In the multi-byte modes a lead byte is held and
// gives no item; its trail byte gives two items, the left half-glyph at
// column - 8 and the right half at the column, from the loaded font at
// 4096 + cell*32 (+16 for the right half). A cell below zero or at or above
// CELL_COUNT raises bad_code and gives offset zero. A zero byte is a string
// terminator and gives nothing. The pen column moves on by 8 for every nonzero
// byte and saturates at 4095; first_of_string loads it from start_x first.
// Rate: one byte is taken every cycle while the command queue has room; the
// result register hands out one item per cycle while items are popped, so a
// double-byte character holds the back part for both of its items and single
// bytes go through at one per cycle. A byte's command passes through the command queue and then the result register.
// QUEUE_DEPTH sets how many decoded commands may wait between the two halves.
// Write the mode register only while the block is idle.
module japanese_text_glyph_decoder_unit #(
    parameter int CELL_COUNT  = 12288,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // mode register
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    // byte side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_char_byte,
    input  logic               i_first_of_string,
    input  logic [11:0]        i_start_x,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic               o_font_select,
    output logic [18:0]        o_glyph_offset,
    output logic signed [12:0] o_draw_x,
    output logic               o_bad_code,
    output logic               o_last
);
    import jtgd_pkg::*;

    logic    accept, q_wr, q_pop, q_full, q_empty;
    t_cmd    cmd, head;
    t_result result;

    // Take a byte whenever the queue can hold its command
    assign full   = q_full;
    assign accept = push && !q_full;

    jtgd_front #(
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_accept          (accept),
        .i_char_byte       (i_char_byte),
        .i_first_of_string (i_first_of_string),
        .i_start_x         (i_start_x),
        .o_wr              (q_wr),
        .o_cmd             (cmd)
    );

    jtgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (cmd),
        .i_rd      (q_pop),
        .o_rd_data (head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    jtgd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    // Hand the result register straight to the ports
    assign o_font_select  = result.font_select;
    assign o_glyph_offset = result.glyph_offset;
    assign o_draw_x       = result.draw_x;
    assign o_bad_code     = result.bad_code;
    assign o_last         = result.last;

endmodule

// ===== rtl/jtgd_front.sv =====
// Front part: mode register, pen column, pending lead byte and byte classification.
// Uses jtgd_pkg; drives one decoded command per accepted nonzero byte that is not a held lead byte into the queue.
module jtgd_front #(
    parameter int CELL_COUNT = 12288
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_first_of_string,
    input  logic [11:0]          i_start_x,
    output logic                 o_wr,
    output jtgd_pkg::t_cmd       o_cmd
);
    import jtgd_pkg::*;

    localparam logic signed [CELL_W-1:0] CellLim = CELL_W'(CELL_COUNT);

    logic [1:0]  r_lang_mode;
    logic [7:0]  r_pending;
    logic [11:0] r_column;
    logic [7:0]  n_pending;
    logic [11:0] n_column;

    logic        is_mb, is_sjis, lead_byte, nul, take_lead, dbl;
    logic [11:0] col_cur;
    logic signed [CELL_W-1:0] lb, sb, row, cp, cell_idx;
    logic        bad;
    logic [18:0] base;

    assign is_sjis = (r_lang_mode == LANG_SJIS);
    assign is_mb   = is_sjis || (r_lang_mode == LANG_EUC);
    assign nul     = (i_char_byte == 8'd0);
    assign col_cur = i_first_of_string ? i_start_x : r_column;

    always_comb begin
        if (is_sjis) begin
            lead_byte = (i_char_byte >= SJIS_LEAD_A_LO && i_char_byte <= SJIS_LEAD_A_HI)
                     || (i_char_byte >= SJIS_LEAD_B_LO && i_char_byte <= SJIS_LEAD_B_HI);
        end else begin
            lead_byte = (i_char_byte >= EUC_LEAD_LO && i_char_byte <= EUC_LEAD_HI);
        end
    end

    assign take_lead = !nul && is_mb && (r_pending == 8'd0) && lead_byte;
    assign dbl       = !nul && is_mb && (r_pending != 8'd0);

    // Row and cell of the double-byte code
    assign lb = signed'({8'd0, r_pending});
    assign sb = signed'({8'd0, i_char_byte});

    always_comb begin
        if (is_sjis) begin
            if (r_pending >= SJIS_LEAD_A_LO && r_pending <= SJIS_LEAD_A_HI) begin
                row = (lb - SJIS_BASE_A) <<< 1;
            end else begin
                row = ((lb - SJIS_BASE_B) <<< 1) + SJIS_ROW_B;
            end
            if (i_char_byte >= SJIS_TRAIL_A_LO && i_char_byte <= SJIS_TRAIL_A_HI) begin
                cp = sb - SJIS_TR_A;
            end else if (i_char_byte >= SJIS_TRAIL_B_LO && i_char_byte <= SJIS_TRAIL_B_HI) begin
                cp = sb - SJIS_TR_B;
            end else begin
                cp  = sb - SJIS_TR_C;
                row = row + 16'sd1;
            end
        end else begin
            row = lb - EUC_BASE;
            cp  = sb - EUC_BASE;
        end
    end

    assign cell_idx = row * CELLS_PER_ROW + cp;
    assign bad      = (cell_idx < 0) || (cell_idx >= CellLim);
    assign base     = bad ? 19'd0 : (NAT_BASE + {cell_idx[13:0], 5'd0});

    always_comb begin
        o_cmd.is_double    = dbl;
        o_cmd.font_select  = is_mb;
        o_cmd.glyph_offset = dbl ? base : {7'd0, i_char_byte, 4'd0};
        o_cmd.column       = col_cur;
        o_cmd.bad_code     = dbl && bad;
    end

    assign o_wr = i_accept && !nul && !take_lead;

    always_comb begin
        n_pending = r_pending;
        if (take_lead) begin
            n_pending = i_char_byte;
        end else if (dbl) begin
            n_pending = 8'd0;
        end
        if (nul) begin
            n_column = col_cur;
        end else if (col_cur >= COL_SAT) begin
            n_column = COL_MAX;
        end else begin
            n_column = col_cur + COL_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lang_mode <= 2'd0;
            r_pending   <= 8'd0;
            r_column    <= 12'd0;
        end else begin
            if (i_cfg_we) begin
                r_lang_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_pending <= n_pending;
                r_column  <= n_column;
            end
        end
    end

endmodule

// ===== rtl/jtgd_queue.sv =====
// Short command queue between the front and back parts.
// Uses jtgd_pkg for the command type; register storage, DEPTH entries.
module jtgd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  jtgd_pkg::t_cmd i_wr_data,
    input  logic           i_rd,
    output jtgd_pkg::t_cmd o_rd_data,
    output logic           o_full,
    output logic           o_empty
);
    import jtgd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/jtgd_back.sv =====
// Back part: expands queued commands into result items through a result
// register, one per cycle if popped. Uses jtgd_pkg for command, result types.
module jtgd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jtgd_pkg::t_cmd    i_head,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output jtgd_pkg::t_result o_result
);
    import jtgd_pkg::*;

    logic    r_valid, r_second;
    t_result r_out;
    logic    n_valid, n_second;
    t_result n_out;
    logic    load;
    logic signed [12:0] x_col;
    t_result res_first, res_last;

    assign load  = !r_valid || i_pop;
    assign x_col = signed'({1'b0, i_head.column});

    always_comb begin
        res_first.font_select  = i_head.font_select;
        res_first.glyph_offset = i_head.glyph_offset;
        res_first.draw_x       = x_col - GLYPH_W;
        res_first.bad_code     = i_head.bad_code;
        res_first.last         = 1'b0;

        // Single byte, or right half of a double (offset moves on by one bitmap)
        res_last.font_select   = i_head.font_select;
        res_last.glyph_offset  = (r_second && !i_head.bad_code)
                               ? (i_head.glyph_offset | HALF_OFS) : i_head.glyph_offset;
        res_last.draw_x        = x_col;
        res_last.bad_code      = i_head.bad_code;
        res_last.last          = 1'b1;
    end

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        if (load) begin
            if (r_second) begin
                n_out    = res_last;
                n_valid  = 1'b1;
                n_second = 1'b0;
                o_q_pop  = 1'b1;
            end else if (!i_q_empty) begin
                n_valid = 1'b1;
                if (i_head.is_double) begin
                    n_out    = res_first;
                    n_second = 1'b1;
                end else begin
                    n_out   = res_last;
                    o_q_pop = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // The head command stays queued until its right half has gone out
    a_second_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_q_empty)
        else $error("right half pending with an empty queue");

    // A non-final item is always a left half of the national font
    a_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_out.last) |-> (r_out.font_select && r_second))
        else $error("non-final item outside a double-byte pair");

    // The right half is the next item loaded after its left half
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && load) |=> (r_valid && r_out.last))
        else $error("right half did not follow its left half");
`endif

endmodule
